// File: sv/b64lw_pkg.sv
// b64lw_pkg: shared types, character codes and alphabet mapping for the
// base64 line-wrapping encoder. No dependencies.
package b64lw_pkg;

  // character codes
  localparam logic [7:0] CH_PAD = 8'd61;
  localparam logic [7:0] CH_NL  = 8'd10;

  // widths
  localparam int unsigned CountW = 3;   // up to six characters per transaction
  localparam int unsigned WcntW  = 16;

  // results caused by one input transaction: an optional group of four
  // characters followed by newlines
  typedef struct packed {
    logic [3:0][7:0]    grp;
    logic               has_grp;
    logic [CountW-1:0]  count;
    logic               done;
    logic [WcntW-1:0]   wcount;
  } burst_t;

  // map a 6-bit index through A-Z a-z 0-9 + /
  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] wide;
    wide = {2'b00, idx};
    if (idx < 6'd26) begin
      b64_char = wide + 8'd65;
    end else if (idx < 6'd52) begin
      b64_char = wide + 8'd71;        // 'a' - 26
    end else if (idx < 6'd62) begin
      b64_char = wide - 8'd4;         // '0' - 52
    end else if (idx == 6'd62) begin
      b64_char = 8'd43;               // '+'
    end else begin
      b64_char = 8'd47;               // '/'
    end
  endfunction

endpackage

// File: sv/b64lw_encode.sv
// b64lw_encode: message state registers and the single-pass logic that turns
// one input transaction into a burst of result characters.
// Depends on b64lw_pkg.
module b64lw_encode #(
  parameter int unsigned LINE_LENGTH = 76
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          data_byte,
  input  logic                has_byte,
  input  logic                end_of_message,
  input  logic                wrap_en,
  output b64lw_pkg::burst_t   burst
);

  localparam logic [7:0] LineLen = 8'(LINE_LENGTH);

  logic [15:0] pend_r,  pend_nxt;
  logic [1:0]  fill_r,  fill_nxt;
  logic [7:0]  lf_r,    lf_nxt;
  logic [15:0] nt_r,    nt_nxt;

  logic        grp_full, g_part, g_emit, nb2, nb3, wrap_nl, close_nl;
  logic [15:0] pend_a, nt_a;
  logic [1:0]  fill_a;
  logic [7:0]  b1, b2, b3, lf_sum, lf_wrapped, lf_a;
  logic [5:0]  i1, i2, i3, i4;

  // group assembly, line position and newline decisions
  always_comb begin
    grp_full = has_byte && (fill_r == 2'd2);
    if (has_byte && !grp_full) begin
      pend_a = {pend_r[7:0], data_byte};
      fill_a = fill_r + 2'd1;
    end else if (grp_full) begin
      pend_a = '0;
      fill_a = '0;
    end else begin
      pend_a = pend_r;
      fill_a = fill_r;
    end

    g_part = end_of_message && !grp_full && (fill_a != 2'd0);
    g_emit = grp_full || g_part;

    if (grp_full) begin
      b1 = pend_r[15:8];
      b2 = pend_r[7:0];
      b3 = data_byte;
    end else if (fill_a == 2'd2) begin
      b1 = pend_a[15:8];
      b2 = pend_a[7:0];
      b3 = '0;
    end else begin
      b1 = pend_a[7:0];
      b2 = '0;
      b3 = '0;
    end
    nb3 = grp_full;
    nb2 = grp_full || (fill_a == 2'd2);

    i1 = b1[7:2];
    i2 = {b1[1:0], b2[7:4]};
    i3 = {b2[3:0], b3[7:6]};
    i4 = b3[5:0];

    lf_sum     = lf_r + 8'd4;
    lf_wrapped = (lf_sum >= LineLen) ? (lf_sum - LineLen) : lf_sum;
    lf_a       = g_emit ? lf_wrapped : lf_r;

    wrap_nl  = g_emit && wrap_en && (lf_wrapped == 8'd0);
    nt_a     = (wrap_nl && (nt_r != 16'hFFFF)) ? (nt_r + 16'd1) : nt_r;
    close_nl = end_of_message && wrap_en;

    burst.grp[0]  = b64lw_pkg::b64_char(i1);
    burst.grp[1]  = b64lw_pkg::b64_char(i2);
    burst.grp[2]  = nb2 ? b64lw_pkg::b64_char(i3) : b64lw_pkg::CH_PAD;
    burst.grp[3]  = nb3 ? b64lw_pkg::b64_char(i4) : b64lw_pkg::CH_PAD;
    burst.has_grp = g_emit;
    burst.count   = (g_emit ? 3'd4 : 3'd0) + {2'b00, wrap_nl} + {2'b00, close_nl};
    burst.done    = end_of_message;
    burst.wcount  = nt_a;

    // end of message returns everything to the idle message state
    if (end_of_message) begin
      pend_nxt = '0;
      fill_nxt = '0;
      lf_nxt   = '0;
      nt_nxt   = '0;
    end else begin
      pend_nxt = pend_a;
      fill_nxt = fill_a;
      lf_nxt   = lf_a;
      nt_nxt   = nt_a;
    end
  end

  // message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      fill_r <= '0;
      lf_r   <= '0;
      nt_r   <= '0;
    end else if (fire) begin
      pend_r <= pend_nxt;
      fill_r <= fill_nxt;
      lf_r   <= lf_nxt;
      nt_r   <= nt_nxt;
    end
  end

endmodule

// File: sv/b64lw_serial.sv
// b64lw_serial: holds one burst of result characters and hands them out one
// per cycle unless stalled, via a registered output stage. Uses b64lw_pkg.
module b64lw_serial (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  b64lw_pkg::burst_t  burst_in,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_char,
  output logic               out_last_of_run,
  output logic               out_message_done,
  output logic [15:0]        out_wrap_count
);

  b64lw_pkg::burst_t burst_r;
  logic              bvld_r;
  logic [2:0]        idx_r;
  logic              out_valid_r;
  logic [7:0]        char_r;
  logic              last_r, done_r;
  logic [15:0]       wcnt_r;

  logic              out_free, send, last;
  logic [7:0]        cur_char;

  // pick the next character of the held burst
  always_comb begin
    out_free = !out_valid_r || !out_stall;
    send     = bvld_r && out_free;
    last     = (idx_r == (burst_r.count - 3'd1));
    if (burst_r.has_grp && !idx_r[2]) begin
      cur_char = burst_r.grp[idx_r[1:0]];
    end else begin
      cur_char = b64lw_pkg::CH_NL;
    end
    busy = bvld_r && !(send && last);
  end

  // burst holding register and output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvld_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (send) begin
        out_valid_r <= 1'b1;
        idx_r       <= idx_r + 3'd1;
        if (last) begin
          bvld_r <= 1'b0;
        end
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        bvld_r <= 1'b1;
        idx_r  <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      burst_r <= burst_in;
    end
    if (send) begin
      char_r <= cur_char;
      last_r <= last;
      done_r <= last && burst_r.done;
      wcnt_r <= (last && burst_r.done) ? burst_r.wcount : 16'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_char         = char_r;
  assign out_last_of_run  = last_r;
  assign out_message_done = done_r;
  assign out_wrap_count   = wcnt_r;

endmodule

// File: sv/base64_line_wrap_encoder.sv
// base64_line_wrap_encoder: streaming base64 encoder with optional line wrap.
// The first result character passes the burst holding register, then the
// output register. Throughput: one result character per cycle while
// out_stall is low; an item gives n results (four per completed group, plus
// newlines); the input stalls while a burst still has results to send.
// Reset (rst_n, synchronous): wrap enabled, message state and queues cleared.
module base64_line_wrap_encoder #(
  parameter int unsigned LINE_LENGTH = 76
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_wrap_enable,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_last_of_run,
  output logic        out_message_done,
  output logic [15:0] out_wrap_count
);

  logic              wrap_en_r;
  logic              in_fire, busy, load;
  b64lw_pkg::burst_t burst;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_en_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      wrap_en_r <= cfg_wrap_enable;
    end
  end

  // input transaction handshake
  assign in_stall = busy;
  assign in_fire  = in_valid && !in_stall;
  assign load     = in_fire && (burst.count != 3'd0);

  b64lw_encode #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_encode (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (in_fire),
    .data_byte      (in_data_byte),
    .has_byte       (in_has_byte),
    .end_of_message (in_end_of_message),
    .wrap_en        (wrap_en_r),
    .burst          (burst)
  );

  b64lw_serial u_serial (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (load),
    .burst_in         (burst),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char         (out_char),
    .out_last_of_run  (out_last_of_run),
    .out_message_done (out_message_done),
    .out_wrap_count   (out_wrap_count)
  );

  // the end of a message is always the last character of its transaction
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_done |-> out_last_of_run)
    else $error("message_done without last_of_run");

  // wrap count only travels with message_done
  a_wcount_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_message_done |-> out_wrap_count == 16'd0)
    else $error("wrap_count set on a non-final character");

  // a load never lands on a burst that still has characters left
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> !$past(busy))
    else $error("burst overwritten while busy");

  // a stalled output character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char))
    else $error("stalled output changed");

endmodule
